### hw/rtl/mbwa_pkg.sv
package mbwa_pkg;

    localparam int DEF_CHANNELS   = 8;
    localparam int DEF_MAX_FRAMES = 64;
    localparam int DEF_MAX_SETS   = 65535;

    localparam int CMD_W    = 2;
    localparam int CH_W     = 3;
    localparam int SMP_W    = 24;
    localparam int ACC_W    = 40;
    localparam int SUM_W    = 32;
    localparam int SET_W    = 16;
    localparam int WIN_W    = 7;
    localparam int EMIT_LIMIT = 8;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd64;

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_CLOSE,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [CH_W-1:0]         ch;
        logic signed [SMP_W-1:0] code;
        logic                    ends;
    } t_op_item;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_DIVF,
        ST_UPD,
        ST_DIVW,
        ST_OUT,
        ST_FIN
    } t_state;

    function automatic logic signed [SMP_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(signed'(24'sh7FFFFF));
        lo = ACC_W'(signed'(24'sh800000));
        if (v > hi) begin
            return 24'sh7FFFFF;
        end else if (v < lo) begin
            return 24'sh800000;
        end
        return v[SMP_W-1:0];
    endfunction

endpackage

### hw/rtl/mbwa_ram.sv
module mbwa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/mbwa_div.sv
module mbwa_div
    import mbwa_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ACC_W-1:0] i_dividend,
    input  logic [SET_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic signed [ACC_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [ACC_W-1:0] r_q;
    logic [SET_W:0]   r_rem;
    logic [SET_W-1:0] r_dsr;
    logic             r_done;
    logic [SET_W:0]   shifted;
    logic [SET_W+1:0] trial;

    // Restoring division on the magnitude, one quotient bit per cycle.
    assign shifted = {r_rem[SET_W-1:0], r_q[ACC_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ACC_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[ACC_W-1];
            r_q   <= i_dividend[ACC_W-1] ? ACC_W'(-i_dividend) : ACC_W'(i_dividend);
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            if (!trial[SET_W+1]) begin
                r_rem <= trial[SET_W:0];
                r_q   <= {r_q[ACC_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_q   <= {r_q[ACC_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -signed'(r_q) : signed'(r_q);

endmodule

### hw/rtl/mbwa_queue.sv
module mbwa_queue
    import mbwa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_op_item i_item,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_valid,
    output t_op_item o_item
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_op_item      r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

### hw/rtl/mbwa_front.sv
module mbwa_front
    import mbwa_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // channel, raw_sample
    input  logic [CMD_W-1:0]  s_axis_tuser,   // command
    input  logic              s_axis_tlast,   // ends_set
    input  logic              i_q_full,
    input  logic              i_init_busy,
    output logic              o_push,
    output t_op_item          o_item
);

    logic [CMD_W-1:0] cmd;
    logic             keep;

    assign cmd           = s_axis_tuser;
    assign s_axis_tready = !i_q_full && !i_init_busy;

    // Unused commands and samples for absent channels never reach the queue.
    always_comb begin
        o_item.ch   = s_axis_tdata[CH_W-1:0];
        o_item.code = signed'(s_axis_tdata[CH_W+SMP_W-1:CH_W]);
        o_item.ends = s_axis_tlast;
        o_item.op   = OP_SAMPLE;
        keep        = 1'b0;
        unique case (cmd)
            CMD_SAMPLE: begin
                o_item.op = OP_SAMPLE;
                keep      = (32'(s_axis_tdata[CH_W-1:0]) < CHANNELS);
            end
            CMD_CLOSE: begin
                o_item.op = OP_CLOSE;
                keep      = 1'b1;
            end
            CMD_CLEAR: begin
                o_item.op = OP_CLEAR;
                keep      = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = s_axis_tvalid && s_axis_tready && keep;

endmodule

### hw/rtl/mbwa_back.sv
module mbwa_back
    import mbwa_pkg::*;
#(
    parameter int CHANNELS   = DEF_CHANNELS,
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int MAX_SETS   = DEF_MAX_SETS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [WIN_W-1:0] i_window_frames,
    input  logic             i_q_valid,
    input  t_op_item         i_q_item,
    output logic             o_q_pop,
    output logic             o_init_busy,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [63:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW    = $clog2(MAX_FRAMES);
    localparam int AW    = SW + CW;
    localparam int DEPTH = 2 ** AW;

    localparam logic signed [ACC_W:0] ACC_HI = {2'b00, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W:0] ACC_LO = {2'b11, {(ACC_W-1){1'b0}}};

    t_state n_state;
    t_state r_state;

    logic signed [ACC_W-1:0] r_acc [CHANNELS];
    logic signed [SUM_W-1:0] r_sum [CHANNELS];
    logic [SET_W-1:0]        r_sets;
    logic [WIN_W-1:0]        r_filled;
    logic [SW-1:0]           r_slot;
    logic [CW-1:0]           r_ch;
    logic [AW-1:0]           r_clr_addr;
    logic                    r_init;
    logic signed [SMP_W-1:0] r_fa;
    logic signed [SMP_W-1:0] r_wa;
    logic                    r_ovalid;
    logic [63:0]             r_odata;
    logic                    r_olast;

    logic [WIN_W-1:0]        win;
    logic                    out_free;
    logic                    emit;
    logic                    last_ch;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_sat;
    logic signed [SUM_W-1:0] new_sum;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [SMP_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [SMP_W-1:0]        ram_rdata;
    logic                    div_start;
    logic signed [ACC_W-1:0] div_dividend;
    logic [SET_W-1:0]        div_divisor;
    logic                    div_done;
    logic signed [ACC_W-1:0] div_quot;

    always_comb begin
        if (i_window_frames == '0) begin
            win = WIN_W'(1);
        end else if (32'(i_window_frames) > MAX_FRAMES) begin
            win = WIN_W'(MAX_FRAMES);
        end else begin
            win = i_window_frames;
        end
    end

    assign out_free = !r_ovalid || m_axis_tready;
    assign emit     = (32'(r_ch) < EMIT_LIMIT);
    assign last_ch  = (r_ch == CW'(CHANNELS - 1));

    // Saturating add of one sample into the addressed accumulator.
    always_comb begin
        acc_sum = (ACC_W+1)'(r_acc[CW'(i_q_item.ch)]) + (ACC_W+1)'(i_q_item.code);
        if (acc_sum > ACC_HI) begin
            acc_sat = ACC_HI[ACC_W-1:0];
        end else if (acc_sum < ACC_LO) begin
            acc_sat = ACC_LO[ACC_W-1:0];
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    assign new_sum = r_sum[r_ch] - SUM_W'(signed'(ram_rdata)) + SUM_W'(r_fa);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR: begin
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_item.op)
                        OP_CLOSE: n_state = ST_RD;
                        OP_CLEAR: n_state = ST_CLR;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RD:   n_state = ST_DIVF;
            ST_DIVF: n_state = div_done ? ST_UPD : ST_DIVF;
            ST_UPD:  n_state = ST_DIVW;
            ST_DIVW: n_state = div_done ? ST_OUT : ST_DIVW;
            ST_OUT: begin
                if (out_free || !emit) begin
                    n_state = last_ch ? ST_FIN : ST_RD;
                end
            end
            ST_FIN:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop      = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = {r_slot, r_ch};
        ram_wdata    = r_fa;
        ram_re       = 1'b0;
        div_start    = 1'b0;
        div_dividend = r_acc[r_ch];
        div_divisor  = r_sets;
        unique case (r_state)
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            ST_IDLE: o_q_pop = i_q_valid;
            ST_RD: begin
                ram_re    = 1'b1;
                div_start = 1'b1;
            end
            ST_UPD: begin
                ram_we       = 1'b1;
                div_start    = 1'b1;
                div_dividend = ACC_W'(new_sum);
                div_divisor  = SET_W'(r_filled);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_init     <= 1'b1;
            r_clr_addr <= '0;
            r_sets     <= '0;
            r_filled   <= '0;
            r_slot     <= '0;
            r_ch       <= '0;
            r_ovalid   <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_acc[i] <= '0;
                r_sum[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && out_free && emit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == '1) begin
                        r_init <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    if (i_q_valid) begin
                        unique case (i_q_item.op)
                            OP_SAMPLE: begin
                                if (32'(r_sets) < MAX_SETS) begin
                                    r_acc[CW'(i_q_item.ch)] <= acc_sat;
                                    r_sets <= r_sets + SET_W'(i_q_item.ends);
                                end
                            end
                            OP_CLOSE: begin
                                r_filled <= (r_filled < win) ? r_filled + 1'b1 : win;
                                r_ch     <= '0;
                            end
                            default: begin
                                r_clr_addr <= '0;
                                r_sets     <= '0;
                                r_filled   <= '0;
                                r_slot     <= '0;
                                for (int i = 0; i < CHANNELS; i++) begin
                                    r_acc[i] <= '0;
                                    r_sum[i] <= '0;
                                end
                            end
                        endcase
                    end
                end
                ST_DIVF: begin
                    if (div_done) begin
                        r_fa <= (r_sets == '0) ? '0 : sat24(div_quot);
                    end
                end
                ST_UPD: begin
                    r_sum[r_ch] <= new_sum;
                    r_acc[r_ch] <= '0;
                end
                ST_DIVW: begin
                    if (div_done) begin
                        r_wa <= sat24(div_quot);
                    end
                end
                ST_OUT: begin
                    if (out_free || !emit) begin
                        r_ch <= r_ch + 1'b1;
                    end
                end
                ST_FIN: begin
                    r_sets <= '0;
                    r_slot <= (32'(r_slot) + 1 >= 32'(win)) ? '0 : r_slot + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free && emit) begin
            r_odata <= {6'd0, r_filled, r_wa, r_fa, CH_W'(r_ch)};
            r_olast <= last_ch || (32'(r_ch) == EMIT_LIMIT - 1);
        end
    end

    mbwa_ram #(
        .WIDTH (SMP_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr ({r_slot, r_ch}),
        .o_rdata (ram_rdata)
    );

    mbwa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign o_init_busy   = r_init;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

endmodule

### hw/rtl/multichannel_block_and_window_average.sv
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: channel[2:0], raw_sample[26:3]; tuser: command; tlast: ends_set
// m_axis    out  tdata: out_channel[2:0], frame_average[26:3], window_average[50:27],
//                frames_filled[57:51]; tlast: last
// cfg       in   i_cfg_we, i_cfg_wdata: window_frames
//
// A sample item is added into its accumulator in the same cycle that it leaves the four-entry queue.
// A close item walks the channels in turn: each channel runs two passes through the
// shared bit-serial divider plus a ring read and write.
// After reset and after a clear item all 2**(SW+CW) ring entries (512 at the defaults)
// are zeroed; input is held off during the reset pass.
// A stalled output register holds the close walk; the queue keeps taking items until it is full.
module multichannel_block_and_window_average
    import mbwa_pkg::*;
#(
    parameter int CHANNELS   = DEF_CHANNELS,
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int MAX_SETS   = DEF_MAX_SETS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,   // channel, raw_sample
    input  logic [CMD_W-1:0] s_axis_tuser,   // command
    input  logic             s_axis_tlast,   // ends_set
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // out_channel, frame_average, window_average,
                                             // frames_filled
    output logic             m_axis_tlast,   // last
    input  logic             i_cfg_we,
    input  logic [WIN_W-1:0] i_cfg_wdata
);

    logic [WIN_W-1:0] r_window_frames;
    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;
    t_op_item         q_in;
    t_op_item         q_out;
    logic             init_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_frames <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window_frames <= i_cfg_wdata;
        end
    end

    mbwa_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .i_q_full      (q_full),
        .i_init_busy   (init_busy),
        .o_push        (q_push),
        .o_item        (q_in)
    );

    mbwa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    mbwa_back #(
        .CHANNELS   (CHANNELS),
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_SETS   (MAX_SETS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_window_frames (r_window_frames),
        .i_q_valid       (q_valid),
        .i_q_item        (q_out),
        .o_q_pop         (q_pop),
        .o_init_busy     (init_busy),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast)
    );

`ifndef SYNTH
    a_no_input_during_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        init_busy |-> !s_axis_tready)
        else $error("input accepted during ring clearing pass");

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    a_no_output_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

### tb/tb_multichannel_block_and_window_average.sv
module tb_multichannel_block_and_window_average;
    timeunit 1ns;
    timeprecision 1ps;
    import mbwa_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int N_CH = DEF_CHANNELS;
    localparam int N_FRAMES = DEF_MAX_FRAMES;
    localparam longint ACC_HI = 64'sd549755813887;
    localparam longint ACC_LO = -64'sd549755813888;
    localparam int SETTLE_CYCLES = 2200;

    typedef struct {
        logic [2:0]  ch;
        logic [23:0] frame_avg;
        logic [23:0] window_avg;
        logic [6:0]  filled;
        logic        last;
    } t_avg_result;

    class avg_scoreboard;
        logic [WIN_W-1:0] window_reg;
        longint acc[N_CH];
        int unsigned sets;
        longint ring[N_FRAMES][N_CH];
        longint sums[N_CH];
        int unsigned filled;
        int unsigned slot;
        t_avg_result expected_q[$];
        int errors;

        function void wipe();
            foreach (acc[i]) acc[i] = 0;
            foreach (sums[i]) sums[i] = 0;
            foreach (ring[f, c]) ring[f][c] = 0;
            sets = 0;
            filled = 0;
            slot = 0;
        endfunction

        function void reset_state();
            window_reg = WINDOW_RESET;
            errors = 0;
            wipe();
        endfunction

        function longint clip24(longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        function void note_item(logic [CMD_W-1:0] cmd, logic [2:0] ch, logic [23:0] raw,
                                logic ends);
            longint sum_v;
            longint fa;
            longint wa;
            int unsigned w;
            int unsigned s;
            t_avg_result r;
            if (cmd == CMD_SAMPLE) begin
                if (sets >= DEF_MAX_SETS) return;
                sum_v = acc[ch] + longint'($signed(raw));
                if (sum_v > ACC_HI) sum_v = ACC_HI;
                if (sum_v < ACC_LO) sum_v = ACC_LO;
                acc[ch] = sum_v;
                if (ends) sets++;
            end else if (cmd == CMD_CLEAR) begin
                wipe();
            end else if (cmd == CMD_CLOSE) begin
                // A zero register acts as one and anything above the ring depth as the depth.
                w = (window_reg == 0) ? 1 :
                    (window_reg > N_FRAMES) ? N_FRAMES : int'(window_reg);
                s = slot % N_FRAMES;
                filled = (filled < w) ? filled + 1 : w;
                for (int i = 0; i < N_CH; i++) begin
                    fa = (sets != 0) ? clip24(acc[i] / longint'(sets)) : 0;
                    sums[i] = sums[i] - ring[s][i] + fa;
                    ring[s][i] = fa;
                    acc[i] = 0;
                    wa = clip24(sums[i] / longint'(filled));
                    r.ch = 3'(i);
                    r.frame_avg = fa[23:0];
                    r.window_avg = wa[23:0];
                    r.filled = 7'(filled);
                    r.last = (i == N_CH - 1);
                    expected_q.push_back(r);
                end
                sets = 0;
                slot = (s + 1 >= w) ? 0 : s + 1;
            end
        endfunction

        function void check_result(logic [63:0] d, logic l);
            t_avg_result e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result data=%h last=%b", $time, d, l);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (d[2:0] !== e.ch) begin
                $display("%0t: channel expected %0d actual %0d", $time, e.ch, d[2:0]);
                errors++;
            end
            if (d[26:3] !== e.frame_avg) begin
                $display("%0t: ch %0d frame average expected %0d actual %0d", $time, e.ch,
                         $signed(e.frame_avg), $signed(d[26:3]));
                errors++;
            end
            if (d[50:27] !== e.window_avg) begin
                $display("%0t: ch %0d window average expected %0d actual %0d", $time, e.ch,
                         $signed(e.window_avg), $signed(d[50:27]));
                errors++;
            end
            if (d[57:51] !== e.filled) begin
                $display("%0t: ch %0d frames filled expected %0d actual %0d", $time, e.ch,
                         e.filled, d[57:51]);
                errors++;
            end
            if (l !== e.last) begin
                $display("%0t: ch %0d last expected %b actual %b", $time, e.ch, e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [31:0]      s_axis_tdata = '0;
    logic [CMD_W-1:0] s_axis_tuser = CMD_SAMPLE;
    logic             s_axis_tlast = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [63:0]      m_axis_tdata;
    logic             m_axis_tlast;
    logic             i_cfg_we = 1'b0;
    logic [WIN_W-1:0] i_cfg_wdata = '0;

    avg_scoreboard avg_sb = new();
    bit gaps_on = 1'b1;

    always #10 i_clk = ~i_clk;

    multichannel_block_and_window_average DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            avg_sb.check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    // Receiver mixes random ready stretches with stall bursts while gaps are enabled.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (gaps_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 9) - 1) @(posedge i_clk);
            end
        end
    end

    // Valid stays high between back-to-back items; it only drops for a gap or in a drain.
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [2:0] ch, logic [23:0] raw,
                             logic ends);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {5'd0, raw, ch};
        s_axis_tlast <= ends;
        do @(posedge i_clk); while (!s_axis_tready);
        avg_sb.note_item(cmd, ch, raw, ends);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (avg_sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(logic [WIN_W-1:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        avg_sb.window_reg = value;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] pick_code();
        case ($urandom_range(0, 7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'hFFFFFF;
            3: return 24'h000000;
            4: return 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_phase(int count);
        int roll;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 84) begin
                send_item(CMD_SAMPLE, 3'($urandom), pick_code(), $urandom_range(0, 7) == 0);
            end else if (roll < 96) begin
                send_item(CMD_CLOSE, 3'($urandom), 24'($urandom), 1'($urandom));
            end else if (roll < 98) begin
                send_item(CMD_CLEAR, 3'($urandom), 24'($urandom), 1'($urandom));
            end else begin
                send_item(CMD_UNUSED, 3'($urandom), 24'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        avg_sb.reset_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_window(7'd3);
        for (int c = 0; c < N_CH; c++) begin
            send_item(CMD_SAMPLE, 3'(c), (c % 2) ? 24'h800000 : 24'h7FFFFF, c == N_CH - 1);
        end
        send_item(CMD_SAMPLE, 3'd5, 24'hFFFFFF, 1'b1);
        send_item(CMD_CLOSE, 3'd0, 24'd0, 1'b0);
        // Close with no completed set gives zero frame averages.
        send_item(CMD_SAMPLE, 3'd2, 24'h123456, 1'b0);
        send_item(CMD_CLOSE, 3'd7, 24'hFFFFFF, 1'b1);
        send_item(CMD_UNUSED, 3'd1, 24'h000001, 1'b1);
        send_item(CMD_CLOSE, 3'd0, 24'd0, 1'b0);
        send_item(CMD_CLOSE, 3'd0, 24'd0, 1'b0);
        send_item(CMD_CLEAR, 3'd0, 24'd0, 1'b0);
        send_item(CMD_SAMPLE, 3'd3, 24'h000010, 1'b1);
        send_item(CMD_CLOSE, 3'd0, 24'd0, 1'b0);

        write_window(7'd0);
        random_phase(90);
        write_window(7'd127);
        random_phase(90);
        // Shrinking the window leaves stale frames in the running sums.
        write_window(7'd2);
        random_phase(90);
        write_window(7'd1);
        random_phase(60);
        write_window(7'($urandom_range(1, 64)));
        gaps_on = 1'b0;
        random_phase(75);

        drain();
        if (avg_sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("%0t: timeout", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
